>>> src/slaq_pkg.sv
// Shared types and constants for the serial line assembler queue.
package slaq_pkg;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CMD_RX_BYTE  = 2'd0,
    CMD_RX_ERROR = 2'd1,
    CMD_READ     = 2'd2,
    CMD_RELEASE  = 2'd3
  } cmd_e;

  // Result status codes
  localparam logic [2:0] ST_NOTHING  = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_QUEUED   = 3'd2;
  localparam logic [2:0] ST_CORRUPT  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // Character constants
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_STORE   = 3'd0,
    OP_TERM    = 3'd1,
    OP_DROP    = 3'd2,
    OP_READ    = 3'd3,
    OP_RELEASE = 3'd4
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic [7:0] data;  // character to store, or read index
  } op_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic       line_ready;
    logic [7:0] read_char;
  } out_word_t;

endpackage

>>> src/slaq_front.sv
// Front end: accepts input words and classifies them into operations.
module slaq_front (
  input  logic              in_valid_i,
  input  slaq_pkg::in_word_t in_word_i,
  output logic              in_stall_o,
  input  logic              q_full_i,
  output logic              push_o,
  output slaq_pkg::op_t     op_o
);
  import slaq_pkg::*;

  logic is_term;
  logic is_print;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the received character
  assign is_term  = (in_word_i.rx_byte == CH_CR) || (in_word_i.rx_byte == CH_LF) ||
                    (in_word_i.rx_byte == CH_FF) || (in_word_i.rx_byte == CH_VT) ||
                    (in_word_i.rx_byte == CH_NUL);
  assign is_print = (in_word_i.rx_byte >= CH_PRINT_LO) && (in_word_i.rx_byte <= CH_PRINT_HI);

  // Decode command into operation
  always_comb begin
    op_o.kind = OP_DROP;
    op_o.data = in_word_i.rx_byte;
    unique case (cmd_e'(in_word_i.command))
      CMD_RX_BYTE: begin
        if (in_word_i.rx_byte == CH_TAB) begin
          op_o.kind = OP_STORE;
          op_o.data = CH_SPACE;
        end else if (is_term) begin
          op_o.kind = OP_TERM;
        end else if (is_print) begin
          op_o.kind = OP_STORE;
        end else begin
          op_o.kind = OP_DROP;
        end
      end
      CMD_RX_ERROR: op_o.kind = OP_DROP;
      CMD_READ: begin
        op_o.kind = OP_READ;
        op_o.data = in_word_i.read_index;
      end
      CMD_RELEASE: op_o.kind = OP_RELEASE;
      default: op_o.kind = OP_DROP;
    endcase
  end

endmodule

>>> src/slaq_queue.sv
// Short operation queue between front and back.
module slaq_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  slaq_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output slaq_pkg::op_t op_o
);
  import slaq_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  op_t             slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

>>> src/slaq_back.sv
// Back end: line store, ring pointers and result register.
module slaq_back #(
  parameter int unsigned LINE_BYTES = 256,
  parameter int unsigned LINE_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  slaq_pkg::op_t       op_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slaq_pkg::out_word_t out_word_o
);
  import slaq_pkg::*;

  localparam int unsigned LenW   = $clog2(LINE_BYTES + 1);
  localparam int unsigned PosW   = $clog2(LINE_BYTES);
  localparam int unsigned SlotW  = $clog2(LINE_SLOTS);
  localparam int unsigned Depth  = LINE_SLOTS * LINE_BYTES;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned IdxW   = (LenW > 8) ? LenW : 8;

  logic [7:0]       mem [Depth];
  logic [7:0]       rdata_q;

  logic [SlotW-1:0] fill_q, fill_d;
  logic [SlotW-1:0] ready_q, ready_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             r_valid_q, r_valid_d;
  logic [2:0]       r_status_q, r_status_d;
  logic             r_ready_q;
  logic             r_rd_q;

  logic             pop;
  logic             ready;
  logic             len_full;
  logic             idx_ok;
  logic [SlotW-1:0] fill_next, ready_next;
  logic             we, re;
  logic [7:0]       wdata;
  logic [AddrW-1:0] waddr, raddr;
  logic [IdxW-1:0]  idx_ext;

  // Take an operation when the result register is free or draining
  assign pop     = q_valid_i && (!r_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  assign ready      = (ready_q != fill_q);
  assign len_full   = (len_q == LenW'(LINE_BYTES));
  assign idx_ext    = IdxW'(op_i.data);
  assign idx_ok     = (idx_ext < IdxW'(LINE_BYTES));
  assign fill_next  = (fill_q == SlotW'(LINE_SLOTS - 1)) ? '0 : fill_q + 1'b1;
  assign ready_next = (ready_q == SlotW'(LINE_SLOTS - 1)) ? '0 : ready_q + 1'b1;

  assign waddr = AddrW'(fill_q) * AddrW'(LINE_BYTES) + AddrW'(len_q[PosW-1:0]);
  assign raddr = AddrW'(ready_q) * AddrW'(LINE_BYTES) + AddrW'(idx_ext[PosW-1:0]);

  // Execute one operation
  always_comb begin
    fill_d     = fill_q;
    ready_d    = ready_q;
    len_d      = len_q;
    r_status_d = ST_NOTHING;
    we         = 1'b0;
    re         = 1'b0;
    wdata      = op_i.data;
    if (pop) begin
      unique case (op_i.kind)
        OP_DROP: begin
          if (len_q != '0) begin
            len_d      = '0;
            r_status_d = ST_CORRUPT;
          end
        end
        OP_STORE: begin
          if (!len_full) begin
            we         = 1'b1;
            len_d      = len_q + 1'b1;
            r_status_d = ST_STORED;
          end
        end
        OP_TERM: begin
          if (len_full) begin
            len_d      = '0;
            r_status_d = ST_TOO_LONG;
          end else if (len_q != '0) begin
            we    = 1'b1;
            wdata = CH_NUL;
            len_d = '0;
            if (fill_next != ready_q) begin
              fill_d     = fill_next;
              r_status_d = ST_QUEUED;
            end else begin
              r_status_d = ST_FULL;
            end
          end
        end
        OP_READ: re = ready && idx_ok;
        OP_RELEASE: begin
          if (ready) begin
            ready_d = ready_next;
          end
        end
        default: r_status_d = ST_NOTHING;
      endcase
    end
  end

  // Result register: load on pop, clear when taken
  always_comb begin
    r_valid_d = r_valid_q;
    if (pop) begin
      r_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      r_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      ready_q   <= '0;
      len_q     <= '0;
      r_valid_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      ready_q   <= ready_d;
      len_q     <= len_d;
      r_valid_q <= r_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      r_status_q <= r_status_d;
      r_ready_q  <= (ready_d != fill_d);
      r_rd_q     <= re;
    end
  end

  // Line store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o           = r_valid_q;
  assign out_word_o.status     = r_status_q;
  assign out_word_o.line_ready = r_ready_q;
  assign out_word_o.read_char  = r_rd_q ? rdata_q : 8'h00;

endmodule

>>> src/serial_line_assembler_queue.sv
// Top level of the serial line assembler queue.
// Assembles received bytes into text lines held in a ring of LINE_SLOTS slots of
// LINE_BYTES bytes, and lets a consumer read and release the oldest finished line.
// Every input word yields exactly one result word. One word is taken per cycle
// when the output is not stalled; an accepted word passes through the front-to-back
// queue and then the back end's result register, and the back end does at most one
// line store write or read as it loads that register. The line store is
// LINE_SLOTS * LINE_BYTES bytes and is not cleared after reset; bytes past a
// line's terminator read back undefined.
module serial_line_assembler_queue #(
  parameter int unsigned LINE_BYTES = 256,
  parameter int unsigned LINE_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slaq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slaq_pkg::out_word_t out_word_o
);
  import slaq_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  op_t  op_in, op_out;

  // Classify incoming words
  slaq_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .op_o       (op_in)
  );

  // Decouple front from back
  slaq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (op_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (op_out)
  );

  // Execute against the line store
  slaq_back #(
    .LINE_BYTES (LINE_BYTES),
    .LINE_SLOTS (LINE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .op_i        (op_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> tb/serial_line_assembler_queue_tb.sv
// Testbench for the serial line assembler queue: directed line cases, then random traffic.
module serial_line_assembler_queue_tb;
  import slaq_pkg::*;

  localparam int unsigned LINE_BYTES     = 256;
  localparam int unsigned LINE_SLOTS     = 8;
  localparam int unsigned TOTAL_WORDS    = 1050;
  localparam int unsigned CALM_FROM      = 900;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 6;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;

  // Mirror of the line ring
  logic [7:0]  slot_bytes   [LINE_SLOTS*LINE_BYTES];
  bit          slot_written [LINE_SLOTS*LINE_BYTES];
  int unsigned nul_pos      [LINE_SLOTS];
  int unsigned fill_idx     = 0;
  int unsigned oldest_idx   = 0;
  int unsigned partial_len  = 0;

  out_word_t   expected_results[$];
  int unsigned words_sent   = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_enable  = 1'b1;

  logic [7:0] terminator_set [5] = '{CH_CR, CH_LF, CH_FF, CH_VT, CH_NUL};

  serial_line_assembler_queue #(
    .LINE_BYTES(LINE_BYTES),
    .LINE_SLOTS(LINE_SLOTS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always #5 clk = ~clk;

  // Classify one received byte and update the partial line
  function automatic logic [2:0] absorb_byte(logic [7:0] c);
    logic        term;
    logic [7:0]  ch;
    int unsigned done_len;
    int unsigned nxt;
    term = c inside {CH_CR, CH_LF, CH_FF, CH_VT, CH_NUL};
    ch = c;
    if (c == CH_TAB) begin
      ch = CH_SPACE;
    end else if (!term && (c < CH_PRINT_LO || c > CH_PRINT_HI)) begin
      if (partial_len > 0) begin
        partial_len = 0;
        return ST_CORRUPT;
      end
      return ST_NOTHING;
    end
    if (partial_len >= LINE_BYTES) begin
      if (term) begin
        partial_len = 0;
        return ST_TOO_LONG;
      end
      return ST_NOTHING;
    end
    if (!term) begin
      slot_bytes[fill_idx*LINE_BYTES + partial_len] = ch;
      slot_written[fill_idx*LINE_BYTES + partial_len] = 1'b1;
      partial_len++;
      return ST_STORED;
    end
    if (partial_len == 0) return ST_NOTHING;
    // Terminate with NUL even when the ring turns out to be full
    slot_bytes[fill_idx*LINE_BYTES + partial_len] = CH_NUL;
    slot_written[fill_idx*LINE_BYTES + partial_len] = 1'b1;
    done_len = partial_len;
    partial_len = 0;
    nxt = (fill_idx + 1) % LINE_SLOTS;
    if (nxt != oldest_idx) begin
      nul_pos[fill_idx] = done_len;
      fill_idx = nxt;
      return ST_QUEUED;
    end
    return ST_FULL;
  endfunction

  // Compute the result word of one accepted input word
  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    logic      ready;
    r = '0;
    ready = (oldest_idx != fill_idx);
    case (cmd_e'(w.command))
      CMD_RX_BYTE: begin
        r.status = absorb_byte(w.rx_byte);
      end
      CMD_RX_ERROR: begin
        if (partial_len > 0) begin
          partial_len = 0;
          r.status = ST_CORRUPT;
        end
      end
      CMD_READ: begin
        if (ready) r.read_char = slot_bytes[oldest_idx*LINE_BYTES + w.read_index];
      end
      default: begin
        if (ready) oldest_idx = (oldest_idx + 1) % LINE_SLOTS;
      end
    endcase
    r.line_ready = (oldest_idx != fill_idx);
    return r;
  endfunction

  // Pick a read position that never touches an unwritten byte
  function automatic logic [7:0] pick_read_index();
    int unsigned idx;
    bit          ready;
    ready = (oldest_idx != fill_idx);
    idx = $urandom_range(0, LINE_BYTES - 1);
    if (ready && ($urandom_range(0, 3) != 0 ||
                  !slot_written[oldest_idx*LINE_BYTES + idx]))
      idx = $urandom_range(0, nul_pos[oldest_idx]);
    return idx[7:0];
  endfunction

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 9) == 0) return CH_TAB;
    return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
  endfunction

  // Send one word, waiting out any stall, and record its expected result
  task automatic send_word(cmd_e cmd, logic [7:0] rx, logic [7:0] idx);
    in_word_t w;
    w.command    = cmd;
    w.rx_byte    = rx;
    w.read_index = idx;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_result(w));
    words_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_word(CMD_RX_BYTE, c, 8'($urandom));
  endtask

  task automatic read_at(logic [7:0] idx);
    send_word(CMD_READ, 8'($urandom), idx);
  endtask

  task automatic release_line();
    send_word(CMD_RELEASE, 8'($urandom), 8'($urandom));
  endtask

  task automatic release_all();
    while (oldest_idx != fill_idx) release_line();
  endtask

  // Random command with random fields
  task automatic send_noise();
    cmd_e cmd;
    cmd = cmd_e'($urandom_range(0, 3));
    if (cmd == CMD_READ) read_at(pick_read_index());
    else send_word(cmd, 8'($urandom), 8'($urandom));
  endtask

  // Empty ring, ignored words, each terminator, tab, bad bytes and errors
  task automatic test_directed_cases();
    read_at(8'hFF);
    release_line();
    send_char(CH_CR);
    send_word(CMD_RX_ERROR, 8'h00, 8'h00);
    send_char(8'h80);
    send_char(CH_PRINT_LO);
    send_char(CH_PRINT_HI);
    send_char(CH_TAB);
    send_char(CH_CR);
    read_at(8'd0);
    read_at(8'd1);
    read_at(8'd2);
    read_at(8'd3);
    release_line();
    send_char("a");
    send_char(CH_LF);
    send_char("b");
    send_char(CH_FF);
    send_char("c");
    send_char(CH_VT);
    send_char("d");
    send_char(CH_NUL);
    send_char("e");
    send_word(CMD_RX_ERROR, 8'hFF, 8'hFF);
    send_char("f");
    send_char(8'h1F);
    send_char("g");
    send_char(8'h7F);
    send_char("h");
    send_char(8'hFF);
    read_at(8'd1);
    release_all();
  endtask

  // Longest line that fits, read back at its last position
  task automatic test_longest_line();
    int unsigned k;
    for (k = 0; k < LINE_BYTES - 1; k++) send_char(text_char());
    send_char(CH_CR);
    read_at(8'd255);
    read_at(8'd254);
    read_at(8'd0);
    release_line();
  endtask

  // Line that overruns the slot: extra bytes ignored, then dropped
  task automatic test_overlong_line();
    int unsigned k;
    for (k = 0; k < LINE_BYTES + 3; k++) send_char(text_char());
    send_char(CH_LF);
    send_char("z");
    send_char(CH_CR);
    read_at(8'd0);
    release_all();
  endtask

  // Fill every usable slot, then drop one line on a full ring
  task automatic test_full_ring();
    int unsigned k;
    for (k = 0; k < LINE_SLOTS; k++) begin
      send_char("Q");
      send_char(8'("0" + k));
      send_char(CH_CR);
    end
    read_at(8'd1);
    read_at(8'd2);
    release_all();
  endtask

  // Mostly well-formed lines with random content, reads and releases; some noise
  task automatic test_random_traffic();
    int unsigned len;
    int unsigned k;
    int unsigned lines;
    int unsigned release_odds;
    lines = 0;
    release_odds = 1;
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent >= CALM_FROM) idle_enable = 1'b0;
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
      end else begin
        len = ($urandom_range(0, 79) == 0) ? $urandom_range(250, 262)
                                            : $urandom_range(0, 12);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 59) == 0) send_noise();
          else send_char(text_char());
        end
        send_char(terminator_set[$urandom_range(0, 4)]);
        repeat ($urandom_range(0, 3)) read_at(pick_read_index());
        if ($urandom_range(0, 3) < release_odds) release_line();
        // Alternate between filling and draining the ring
        lines++;
        if (lines % 30 == 0) release_odds = (release_odds == 1) ? 3 : 1;
      end
    end
  endtask

  // Stall the result side in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: status %0d", out_word.status);
        fail_count++;
      end else begin
        exp_w = expected_results.pop_front();
        if (out_word.status !== exp_w.status) begin
          $error("status: expected %0d, actual %0d", exp_w.status, out_word.status);
          fail_count++;
        end
        if (out_word.line_ready !== exp_w.line_ready) begin
          $error("line_ready: expected %0d, actual %0d",
                 exp_w.line_ready, out_word.line_ready);
          fail_count++;
        end
        if (out_word.read_char !== exp_w.read_char) begin
          $error("read_char: expected %0h, actual %0h",
                 exp_w.read_char, out_word.read_char);
          fail_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_longest_line();
    test_overlong_line();
    test_full_ring();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
